[sv/hht_pkg.sv]
// Shared types, codes and constants for the hopscotch hash table unit.
// No dependencies.
package hht_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int SLOT_W       = 11;
  localparam int CNT_OUT_W    = 11;
  localparam int ENT_W        = 1 + KEY_W + VAL_W;

  localparam int TABLE_LOG2_D  = 10;
  localparam int HOP_RANGE_D   = 32;
  localparam int PROBE_RANGE_D = 128;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_PRESENT  = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [2:0]           status;
    logic [VAL_W-1:0]     value;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_OUT_W-1:0] count;
    logic                 grow;
  } res_t;

  typedef struct packed {
    logic ent_we;
    logic hop_we;
  } mem_ctl_t;

endpackage

[sv/hopscotch_hash_table_unit.sv]
// Top level of the hopscotch hash table unit: stream ports and result register.
// Depends on hht_pkg, hht_store and hht_ctrl.
//
// One request (lookup, insert if absent, remove) is handled at a time by a
// sequencer over one entry memory and one hop bitmap memory, each with a
// single registered port. After reset a clearing pass over all
// CAP + PROBE_RANGE buckets (1152 at the defaults) zeroes the table; no
// item is taken meanwhile. The hop scan, the linear probe and the
// displacement moves all share the single port of each memory. The result
// sits in an output register, so the next item is taken while a result
// still waits.
module hopscotch_hash_table_unit import hht_pkg::*; #(
  parameter int TABLE_LOG2  = TABLE_LOG2_D,
  parameter int HOP_RANGE   = HOP_RANGE_D,
  parameter int PROBE_RANGE = PROBE_RANGE_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // hash_code[31:0], key[63:32], value[95:64]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // value_out[31:0], slot[42:32],
                                  // entry_count[53:43], grow_wanted[54], zero
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int NBUCK = (1 << TABLE_LOG2) + PROBE_RANGE;
  localparam int AW    = $clog2(NBUCK);

  mem_ctl_t             ctl;
  logic [AW-1:0]        ent_addr, hop_addr;
  logic [ENT_W-1:0]     ent_wdata, ent_rdata;
  logic [HOP_RANGE-1:0] hop_wdata, hop_rdata;
  logic                 res_valid, res_ready;
  res_t                 res;
  res_t                 out_r;
  logic                 out_valid_r;

  assign res_ready = !out_valid_r || out_tready;

  hht_ctrl #(
    .TABLE_LOG2 (TABLE_LOG2),
    .HOP_RANGE  (HOP_RANGE),
    .PROBE_RANGE(PROBE_RANGE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_hash  (in_tdata[31:0]),
    .in_key   (in_tdata[63:32]),
    .in_value (in_tdata[95:64]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ctl      (ctl),
    .ent_addr (ent_addr),
    .ent_wdata(ent_wdata),
    .ent_rdata(ent_rdata),
    .hop_addr (hop_addr),
    .hop_wdata(hop_wdata),
    .hop_rdata(hop_rdata)
  );

  hht_store #(
    .DEPTH (NBUCK),
    .ADDR_W(AW),
    .HOP_W (HOP_RANGE)
  ) u_store (
    .clk      (clk),
    .ctl      (ctl),
    .ent_addr (ent_addr),
    .ent_wdata(ent_wdata),
    .ent_rdata(ent_rdata),
    .hop_addr (hop_addr),
    .hop_wdata(hop_wdata),
    .hop_rdata(hop_rdata)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {1'b0, out_r.grow, out_r.count, out_r.slot, out_r.value};

endmodule

[sv/hht_store.sv]
// Bucket storage: entry memory (used, key, value) and hop bitmap memory.
// Depends on hht_pkg. Reads are registered: read data appears in the cycle after the address.
module hht_store import hht_pkg::*; #(
  parameter int DEPTH  = 1152,
  parameter int ADDR_W = 11,
  parameter int HOP_W  = 32
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] ent_addr,
  input  logic [ENT_W-1:0]  ent_wdata,
  output logic [ENT_W-1:0]  ent_rdata,
  input  logic [ADDR_W-1:0] hop_addr,
  input  logic [HOP_W-1:0]  hop_wdata,
  output logic [HOP_W-1:0]  hop_rdata
);

  logic [ENT_W-1:0] ent_mem [DEPTH];
  logic [HOP_W-1:0] hop_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.hop_we) begin
      hop_mem[hop_addr] <= hop_wdata;
    end
    hop_rdata <= hop_mem[hop_addr];
  end

endmodule

[sv/hht_ctrl.sv]
// Request sequencer: reset clearing pass, hop scan, linear probe, displacement and result build.
// Depends on hht_pkg; drives the ports of hht_store.
module hht_ctrl import hht_pkg::*; #(
  parameter int TABLE_LOG2  = TABLE_LOG2_D,
  parameter int HOP_RANGE   = HOP_RANGE_D,
  parameter int PROBE_RANGE = PROBE_RANGE_D,
  localparam int CAP    = 1 << TABLE_LOG2,
  localparam int NBUCK  = CAP + PROBE_RANGE,
  localparam int AW     = $clog2(NBUCK),
  localparam int HB_W   = $clog2(HOP_RANGE),
  localparam int OFF_W  = $clog2(PROBE_RANGE),
  localparam int CNT_W  = $clog2(NBUCK + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  input  logic [31:0]      in_hash,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output mem_ctl_t         ctl,
  output logic [AW-1:0]    ent_addr,
  output logic [ENT_W-1:0] ent_wdata,
  input  logic [ENT_W-1:0] ent_rdata,
  output logic [AW-1:0]    hop_addr,
  output logic [HOP_RANGE-1:0] hop_wdata,
  input  logic [HOP_RANGE-1:0] hop_rdata
);

  localparam int THR = (CAP >> 2) + (CAP >> 3);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HOME  = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_FCHK  = 4'd4;
  localparam logic [3:0] S_DISP  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCK   = 4'd7;
  localparam logic [3:0] S_MHRD  = 4'd8;
  localparam logic [3:0] S_MHCK  = 4'd9;
  localparam logic [3:0] S_MERD  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_RES   = 4'd12;

  function automatic logic [HB_W-1:0] low_bit(input logic [HOP_RANGE-1:0] v);
    logic [HB_W-1:0] b;
    b = '0;
    for (int i = HOP_RANGE - 1; i >= 0; i--) begin
      if (v[i]) b = HB_W'(i);
    end
    return b;
  endfunction

  logic [3:0]           st_r, st_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [AW-1:0]        home_r, home_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [HOP_RANGE-1:0] hhop_r, hhop_nxt;
  logic [HOP_RANGE-1:0] scan_r, scan_nxt;
  logic [HB_W-1:0]      bsel_r, bsel_nxt;
  logic                 idxok_r, idxok_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [VAL_W-1:0]     vout_r, vout_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [AW-1:0]        at_r, at_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [AW-1:0]        cur_r, cur_nxt;
  logic [HB_W-1:0]      d_r, d_nxt;
  logic [HB_W-1:0]      mvb_r, mvb_nxt;
  logic [HOP_RANGE-1:0] mvhop_r, mvhop_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 e_used;
  logic [KEY_W-1:0]     e_key;
  logic [VAL_W-1:0]     e_val;
  logic [HB_W-1:0]      fb, hb;
  logic [AW:0]          fidx;
  logic [AW-1:0]        new_at;
  logic [OFF_W-1:0]     new_off;

  assign e_used = ent_rdata[ENT_W-1];
  assign e_key  = ent_rdata[KEY_W+VAL_W-1:VAL_W];
  assign e_val  = ent_rdata[VAL_W-1:0];
  assign fb     = low_bit(scan_r);
  assign hb     = low_bit(hop_rdata);
  assign fidx   = {1'b0, home_r} + (AW+1)'(fb);
  assign new_at  = cur_r + AW'(mvb_r);
  assign new_off = off_r - OFF_W'(d_r - mvb_r);

  assign in_ready  = (st_r == S_IDLE);
  assign res_valid = (st_r == S_RES);

  always_comb begin
    res.status = status_r;
    res.value  = vout_r;
    res.slot   = SLOT_W'(slot_r);
    res.count  = CNT_OUT_W'(count_r);
    res.grow   = (32'(count_r) >= 32'(CAP)) ||
                 (32'(CAP) - 32'(count_r) <= 32'(THR));
  end

  always_comb begin
    st_nxt = st_r;       clr_nxt = clr_r;     kind_nxt = kind_r;
    home_nxt = home_r;   key_nxt = key_r;     val_nxt = val_r;
    hhop_nxt = hhop_r;   scan_nxt = scan_r;   bsel_nxt = bsel_r;
    idxok_nxt = idxok_r; hit_nxt = hit_r;     slot_nxt = slot_r;
    vout_nxt = vout_r;   status_nxt = status_r;
    at_nxt = at_r;       off_nxt = off_r;     cur_nxt = cur_r;
    d_nxt = d_r;         mvb_nxt = mvb_r;     mvhop_nxt = mvhop_r;
    count_nxt = count_r;
    ctl = '0;
    ent_addr  = at_r;
    ent_wdata = '0;
    hop_addr  = home_r;
    hop_wdata = '0;

    case (st_r)
      S_CLEAR: begin
        ent_addr = clr_r;
        hop_addr = clr_r;
        ctl.ent_we = 1'b1;
        ctl.hop_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == NBUCK - 1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        hop_addr = AW'(in_hash[TABLE_LOG2-1:0]);
        if (in_valid) begin
          kind_nxt   = in_kind;
          home_nxt   = AW'(in_hash[TABLE_LOG2-1:0]);
          key_nxt    = in_key;
          val_nxt    = in_value;
          hit_nxt    = 1'b0;
          slot_nxt   = '0;
          vout_nxt   = '0;
          status_nxt = ST_NOTFOUND;
          st_nxt     = S_HOME;
        end
      end
      S_HOME: begin
        hhop_nxt = hop_rdata;
        scan_nxt = hop_rdata;
        st_nxt   = S_FIND;
      end
      S_FIND: begin
        ent_addr = fidx[AW-1:0];
        if (scan_r == '0) begin
          st_nxt = S_DISP;
        end else begin
          bsel_nxt  = fb;
          idxok_nxt = (32'(fidx) < NBUCK);
          scan_nxt  = scan_r & ~(HOP_RANGE'(1) << fb);
          st_nxt    = S_FCHK;
        end
      end
      S_FCHK: begin
        if (idxok_r && e_used && e_key == key_r) begin
          hit_nxt  = 1'b1;
          slot_nxt = home_r + AW'(bsel_r);
          vout_nxt = e_val;
          st_nxt   = S_DISP;
        end else begin
          st_nxt = S_FIND;
        end
      end
      S_DISP: begin
        ent_addr = slot_r;
        st_nxt   = S_RES;
        case (kind_r)
          KIND_REMOVE: begin
            if (hit_r) begin
              ctl.ent_we = 1'b1;
              ctl.hop_we = 1'b1;
              ent_wdata  = {1'b0, key_r, vout_r};
              hop_wdata  = hhop_r & ~(HOP_RANGE'(1) << bsel_r);
              if (count_r != '0) count_nxt = count_r - 1'b1;
              status_nxt = ST_REMOVED;
            end
          end
          KIND_INSERT: begin
            if (hit_r) begin
              status_nxt = ST_PRESENT;
            end else begin
              at_nxt  = home_r;
              off_nxt = '0;
              st_nxt  = S_PRD;
            end
          end
          default: begin
            if (hit_r) status_nxt = ST_FOUND;
          end
        endcase
      end
      S_PRD: begin
        st_nxt = S_PCK;
      end
      S_PCK: begin
        if (!e_used) begin
          // claim the free bucket, then pull it towards home if too far
          ctl.ent_we = 1'b1;
          ent_wdata  = {1'b1, e_key, e_val};
          if (32'(off_r) >= 32'(HOP_RANGE)) begin
            cur_nxt = at_r - AW'(HOP_RANGE - 1);
            d_nxt   = HB_W'(HOP_RANGE - 1);
            st_nxt  = S_MHRD;
          end else begin
            st_nxt = S_FIN;
          end
        end else if (32'(off_r) == PROBE_RANGE - 1) begin
          status_nxt = ST_FULL;
          st_nxt     = S_RES;
        end else begin
          at_nxt  = at_r + 1'b1;
          off_nxt = off_r + 1'b1;
          st_nxt  = S_PRD;
        end
      end
      S_MHRD: begin
        hop_addr = cur_r;
        st_nxt   = S_MHCK;
      end
      S_MHCK: begin
        ent_addr = cur_r + AW'(hb);
        if (hop_rdata != '0 && hb < d_r) begin
          mvb_nxt   = hb;
          mvhop_nxt = hop_rdata;
          st_nxt    = S_MERD;
        end else if (d_r == HB_W'(1)) begin
          // no candidate: release the claimed bucket
          ent_addr   = at_r;
          ctl.ent_we = 1'b1;
          ent_wdata  = '0;
          status_nxt = ST_FULL;
          st_nxt     = S_RES;
        end else begin
          cur_nxt = cur_r + 1'b1;
          d_nxt   = d_r - 1'b1;
          st_nxt  = S_MHRD;
        end
      end
      S_MERD: begin
        ent_addr   = at_r;
        hop_addr   = cur_r;
        ctl.ent_we = 1'b1;
        ctl.hop_we = 1'b1;
        ent_wdata  = {1'b1, e_key, e_val};
        hop_wdata  = (mvhop_r | (HOP_RANGE'(1) << d_r)) & ~(HOP_RANGE'(1) << mvb_r);
        at_nxt     = new_at;
        off_nxt    = new_off;
        if (32'(new_off) >= 32'(HOP_RANGE)) begin
          cur_nxt = new_at - AW'(HOP_RANGE - 1);
          d_nxt   = HB_W'(HOP_RANGE - 1);
          st_nxt  = S_MHRD;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ent_addr   = at_r;
        ctl.ent_we = 1'b1;
        ctl.hop_we = 1'b1;
        ent_wdata  = {1'b1, key_r, val_r};
        hop_wdata  = hhop_r | (HOP_RANGE'(1) << off_r);
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_INSERTED;
        slot_nxt   = at_r;
        st_nxt     = S_RES;
      end
      S_RES: begin
        if (res_ready) st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;   home_r <= home_nxt;   key_r <= key_nxt;
    val_r <= val_nxt;     hhop_r <= hhop_nxt;   scan_r <= scan_nxt;
    bsel_r <= bsel_nxt;   idxok_r <= idxok_nxt; hit_r <= hit_nxt;
    slot_r <= slot_nxt;   vout_r <= vout_nxt;   status_r <= status_nxt;
    at_r <= at_nxt;       off_r <= off_nxt;     cur_r <= cur_nxt;
    d_r <= d_nxt;         mvb_r <= mvb_nxt;     mvhop_r <= mvhop_nxt;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r != S_IDLE))
    else $error("sequencer idle right after accepting an item");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= NBUCK)
    else $error("entry count above bucket count");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> (!in_ready && !res_valid))
    else $error("handshake open during clearing pass");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_DISP && st_r != S_FIN) |=> $stable(count_r))
    else $error("entry count changed outside update states");
`endif

endmodule
